// ----- hdl/spt_pkg.sv -----
package spt_pkg;

    // Fixed field widths
    localparam int CFG_W     = 16;
    localparam int SPAN_W    = 10;
    localparam int ANGLE_W   = 10;
    localparam int CH_W      = 2;
    localparam int ADDR_W    = 3;
    localparam int LEVELS_W  = 4;

    // Block sizing
    localparam int CHANNELS  = 4;
    localparam int CNT_W     = 16;

    // Angle-to-compare arithmetic: 16 x 10 product, restoring division
    localparam int PROD_W     = CFG_W + ANGLE_W;
    localparam int REM_W      = SPAN_W + 1;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [CFG_W-1:0]  PRESCALE_RST    = CFG_W'(0);
    localparam logic [CFG_W-1:0]  PERIOD_TOP_RST  = CFG_W'(19999);
    localparam logic [CFG_W-1:0]  MIN_COUNT_RST   = CFG_W'(1000);
    localparam logic [CFG_W-1:0]  MAX_COUNT_RST   = CFG_W'(2000);
    localparam logic [SPAN_W-1:0] SPAN_RST        = SPAN_W'(180);
    localparam logic [CNT_W-1:0]  COMPARE_RST     = CNT_W'(1000);

    typedef enum logic [ADDR_W-1:0] {
        REG_PRESCALE    = 3'd0,
        REG_PERIOD_TOP  = 3'd1,
        REG_MIN_COUNT   = 3'd2,
        REG_MAX_COUNT   = 3'd3,
        REG_DEGREE_SPAN = 3'd4
    } t_reg_idx;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_MOVE = 1'b1
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code            command;
        logic [CH_W-1:0]      channel;
        logic [ANGLE_W-1:0]   angle;
    } t_in_item;

    typedef struct packed {
        logic [LEVELS_W-1:0]  pwm_levels;
        logic                 period_start;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic do_tick;
        logic latch_move;
        logic mul_load;
        logic div_step;
        logic finish_move;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
        logic div_last;
    } t_dp_stat;

endpackage

// ----- hdl/spt_ctrl.sv -----
module spt_ctrl
    import spt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_cmd_code i_command,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd,
    output logic      o_in_stall
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = (r_state == ST_IDLE) && i_in_valid && i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_command == CMD_MOVE) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall       = !i_stat.out_free;
                o_cmd.do_tick    = accept && (i_command == CMD_TICK);
                o_cmd.latch_move = accept && (i_command == CMD_MOVE);
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish_move = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_mul_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |-> $past(r_state) == ST_IDLE)
        else $error("multiply step not entered from idle");

    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_DONE) |-> $past(r_state) == ST_DIV)
        else $error("write-back entered without finishing the division");

endmodule

// ----- hdl/spt_datapath.sv -----
module spt_datapath
    import spt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  t_in_item          i_in_data,
    input  logic              i_out_stall,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    output t_out_item         o_out_data
);

    // configuration
    logic [CFG_W-1:0]  r_prescale;
    logic [CFG_W-1:0]  r_period_top;
    logic [CFG_W-1:0]  r_min_count;
    logic [CFG_W-1:0]  r_max_count;
    logic [SPAN_W-1:0] r_degree_span;

    // timer state
    logic [CFG_W-1:0] r_prescale_count;
    logic [CNT_W-1:0] r_period_count;
    logic [CNT_W-1:0] r_preload [CHANNELS];
    logic [CNT_W-1:0] r_active  [CHANNELS];

    logic [CFG_W-1:0] n_prescale_count;
    logic [CNT_W-1:0] n_period_count;
    logic [CNT_W-1:0] n_active  [CHANNELS];

    // move arithmetic
    logic [CH_W-1:0]    r_mv_channel;
    logic [ANGLE_W-1:0] r_mv_angle;
    logic               r_up;
    logic [REM_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_quot;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // output stage
    logic      r_out_valid;
    t_out_item r_out;

    logic ps_wrap;
    logic pc_wrap;
    logic out_free;
    logic out_take;
    logic [LEVELS_W-1:0] lv_next;
    logic [LEVELS_W-1:0] lv_now;
    logic [ANGLE_W-1:0]  a_clamp;
    logic [CFG_W-1:0]    diff;
    logic                up;
    logic [REM_W-1:0]    rem_sh;
    logic                q_bit;
    logic [CNT_W-1:0]    q_val;
    logic [CNT_W-1:0]    move_value;

    // ---------------- configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale    <= PRESCALE_RST;
            r_period_top  <= PERIOD_TOP_RST;
            r_min_count   <= MIN_COUNT_RST;
            r_max_count   <= MAX_COUNT_RST;
            r_degree_span <= SPAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PRESCALE:    r_prescale    <= i_cfg_wdata;
                REG_PERIOD_TOP:  r_period_top  <= i_cfg_wdata;
                REG_MIN_COUNT:   r_min_count   <= i_cfg_wdata;
                REG_MAX_COUNT:   r_max_count   <= i_cfg_wdata;
                REG_DEGREE_SPAN: r_degree_span <= i_cfg_wdata[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- prescaler, period counter, update event
    assign ps_wrap = (r_prescale_count >= r_prescale);
    assign pc_wrap = ps_wrap && (r_period_count >= r_period_top);

    always_comb begin
        n_prescale_count = ps_wrap ? '0 : r_prescale_count + CFG_W'(1);
        if (pc_wrap) begin
            n_period_count = '0;
        end else if (ps_wrap) begin
            n_period_count = r_period_count + CNT_W'(1);
        end else begin
            n_period_count = r_period_count;
        end
        for (int i = 0; i < CHANNELS; i++) begin
            n_active[i] = pc_wrap ? r_preload[i] : r_active[i];
        end
    end

    // PWM mode 1: high while counter below active compare
    always_comb begin
        lv_next = '0;
        lv_now  = '0;
        for (int i = 0; i < LEVELS_W; i++) begin
            if (i < CHANNELS) begin
                lv_next[i] = n_period_count < n_active[i];
                lv_now[i]  = r_period_count < r_active[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_count <= '0;
            r_period_count   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_active[i] <= COMPARE_RST;
            end
        end else if (i_cmd.do_tick) begin
            r_prescale_count <= n_prescale_count;
            r_period_count   <= n_period_count;
            for (int i = 0; i < CHANNELS; i++) begin
                r_active[i] <= n_active[i];
            end
        end
    end

    // ---------------- angle to compare: multiply, then bit-serial divide
    assign a_clamp = (r_mv_angle > r_degree_span) ? r_degree_span : r_mv_angle;
    assign up      = (r_max_count >= r_min_count);
    assign diff    = up ? (r_max_count - r_min_count) : (r_min_count - r_max_count);

    assign rem_sh = {r_rem[REM_W-2:0], r_quot[PROD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_degree_span});

    // quotient never exceeds diff, so the low bits hold it
    assign q_val      = (r_degree_span == '0) ? '0 : r_quot[CNT_W-1:0];
    assign move_value = r_up ? (r_min_count + q_val) : (r_min_count - q_val);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_move) begin
            r_mv_channel <= i_in_data.channel;
            r_mv_angle   <= i_in_data.angle;
        end
        if (i_cmd.mul_load) begin
            r_up   <= up;
            r_rem  <= '0;
            r_quot <= PROD_W'(diff) * PROD_W'(a_clamp);
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? (rem_sh - {1'b0, r_degree_span}) : rem_sh;
            r_quot <= {r_quot[PROD_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.mul_load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_preload[i] <= COMPARE_RST;
            end
        end else if (i_cmd.finish_move && (int'(r_mv_channel) < CHANNELS)) begin
            r_preload[r_mv_channel] <= move_value;
        end
    end

    // ---------------- output register
    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_tick || i_cmd.finish_move) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_tick) begin
            r_out.pwm_levels   <= lv_next;
            r_out.period_start <= pc_wrap;
        end else if (i_cmd.finish_move) begin
            r_out.pwm_levels   <= lv_now;
            r_out.period_start <= 1'b0;
        end
    end

    assign o_stat.out_free = out_free;
    assign o_stat.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    // count rests at DIV_STEPS after the last step until the next move
    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_cnt <= DIV_CNT_W'(DIV_STEPS))
        else $error("divider step count overran");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish_move && r_degree_span != '0 |-> r_quot[PROD_W-1:CNT_W] == '0)
        else $error("move quotient wider than a compare value");

    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.period_start |-> r_period_count == '0)
        else $error("period start reported while counter not at zero");

endmodule

// ----- hdl/servo_pwm_timer.sv -----
// Four-channel servo PWM timer. Each input transfer is either a tick of the
// timer clock or a move of one channel, and each produces exactly one output
// transfer carrying the four PWM levels (sampled after the item) and a flag
// for the update event. A tick is accepted every cycle while the block is
// idle and the output register is free or being drained; its result is
// registered and shows in the cycle after. A move is captured, runs the
// 16x10 multiply and the bit-serial restoring divide by degree_span, then
// writes the preload register and loads the result; the input stalls from
// the capture to the write-back, longer if the output register is held. New
// compare values go live at the next counter wrap. Configuration registers
// must be written only while the block is idle; this is not enforced.
module servo_pwm_timer
    import spt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // configuration write port
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,

    // input channel
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_stall,

    // output channel
    output logic              o_out_valid,
    output t_out_item         o_out_data,
    input  logic              i_out_stall
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: ticks straight from idle, moves through multiply and divide
    spt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // counters, compare registers, divider and output register
    spt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
